>>> rtl/core/gpc_pkg.sv
`timescale 1ns / 1ps

package gpc_pkg;

  localparam int MAX_COLS  = 4096;
  localparam int MAX_ROWS  = 4096;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int SIZE_W    = 13;
  localparam int CNT_W     = 30;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] PRIME_MOD = 30'd1000000009;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [SIZE_W-1:0] size_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_EAST  = 2'd0,
    KIND_SOUTH = 2'd1,
    KIND_BOTH  = 2'd2,
    KIND_GOAL  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } cfg_reg_t;

  // Control carried alongside a cell while its line buffer read is in flight.
  typedef struct packed {
    kind_t kind;
    col_t  col;
    logic  below_zero;
    logic  right_zero;
    logic  last;
  } cell_ctl_t;

  // Both operands are below the prime, so one conditional subtract suffices.
  function automatic count_t add_mod(count_t a, count_t b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME_MOD}) begin
      s = s - {1'b0, PRIME_MOD};
    end
    return s[CNT_W-1:0];
  endfunction

  // A size of zero acts as one, a size above the limit acts as the limit.
  function automatic col_t cols_m1(size_t v);
    size_t d;
    d = v - size_t'(1);
    if (v == '0) begin
      return '0;
    end
    if (int'(v) > MAX_COLS) begin
      return col_t'(MAX_COLS - 1);
    end
    return col_t'(d);
  endfunction

  function automatic row_t rows_m1(size_t v);
    size_t d;
    d = v - size_t'(1);
    if (v == '0) begin
      return '0;
    end
    if (int'(v) > MAX_ROWS) begin
      return row_t'(MAX_ROWS - 1);
    end
    return row_t'(d);
  endfunction

endpackage

>>> rtl/core/gpc_if.sv
`timescale 1ns / 1ps

interface gpc_in_if import gpc_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t cell_kind;

  modport source (output valid, output cell_kind, input ready);
  modport sink (input valid, input cell_kind, output ready);
endinterface

interface gpc_out_if import gpc_pkg::*; ();
  logic   valid;
  logic   ready;
  count_t running_total;
  count_t cell_count;
  logic   last_cell;

  modport source (output valid, output running_total, output cell_count, output last_cell,
                  input ready);
  modport sink (input valid, input running_total, input cell_count, input last_cell,
                output ready);
endinterface

>>> rtl/core/gpc_ram.sv
`timescale 1ns / 1ps

module gpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/grid_path_count_mod.sv
`timescale 1ns / 1ps
// Channel   Dir  Fields                                  Handshake
// in_ch     in   cell_kind[1:0]                          valid/ready
// out_ch    out  running_total[29:0] cell_count[29:0]    valid/ready
//                last_cell
// cfg_*     in   cfg_index[0] cfg_data[12:0]             cfg_we, no wait
//
// One cell is taken every cycle while the output is not stalled. A cell waits in the
// read stage, where the line buffer RAM returns the count of the cell below, then moves
// into the output register, from which the result is offered.
// The path from the right-neighbour register through two modular adds into the
// running total sets the clock.
// Synchronous reset leaves a 1 x 1 grid; the line buffer is not cleared.
// A stalled output holds the read stage, which in turn holds the input.

module grid_path_count_mod import gpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  gpc_in_if.sink               in_ch,
  gpc_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  col_t      cols_m1_r, col_r;
  row_t      rows_m1_r, row_r;
  cell_ctl_t s1_r;
  logic      s1_v_r;
  logic      fwd_v_r;
  count_t    fwd_cnt_r;
  count_t    right_r;
  count_t    total_r, total_nxt;
  logic      out_v_r;
  count_t    out_total_r, out_count_r;
  logic      out_last_r;

  logic      in_acc, s1_adv;
  cell_ctl_t in_ctl;
  count_t    ram_rdata, below, below_sel, right_sel, count;
  count_t    new_total;

  assign s1_adv      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    in_ctl.kind       = in_ch.cell_kind;
    in_ctl.col        = col_r;
    in_ctl.below_zero = (row_r == rows_m1_r);
    in_ctl.right_zero = (col_r == cols_m1_r);
    in_ctl.last       = (row_r == '0) && (col_r == '0);
  end

  gpc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_COLS)
  ) u_line_buf (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_r.col),
    .wdata (count),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // With a single column the cell below is the one written in the same cycle
  // as the read, so its count is taken from the read stage directly.
  assign below = fwd_v_r ? fwd_cnt_r : ram_rdata;

  always_comb begin
    below_sel = '0;
    right_sel = '0;
    if ((s1_r.kind == KIND_SOUTH || s1_r.kind == KIND_BOTH) && !s1_r.below_zero) begin
      below_sel = below;
    end
    if ((s1_r.kind == KIND_EAST || s1_r.kind == KIND_BOTH) && !s1_r.right_zero) begin
      right_sel = right_r;
    end
    if (s1_r.kind == KIND_GOAL) begin
      count = count_t'(1);
    end else begin
      count = add_mod(below_sel, right_sel);
    end
    new_total = add_mod(total_r, count);
    total_nxt = s1_r.last ? '0 : new_total;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_m1_r <= '0;
      rows_m1_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
      total_r   <= '0;
      s1_v_r    <= 1'b0;
      fwd_v_r   <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_GRID_ROWS: begin
            rows_m1_r <= rows_m1(cfg_data);
            row_r     <= rows_m1(cfg_data);
            col_r     <= cols_m1_r;
            total_r   <= '0;
          end
          REG_GRID_COLS: begin
            cols_m1_r <= cols_m1(cfg_data);
            col_r     <= cols_m1(cfg_data);
            row_r     <= rows_m1_r;
            total_r   <= '0;
          end
          default: ;
        endcase
      end else if (in_acc) begin
        if (in_ctl.last) begin
          col_r <= cols_m1_r;
          row_r <= rows_m1_r;
        end else if (col_r == '0) begin
          col_r <= cols_m1_r;
          row_r <= row_r - row_t'(1);
        end else begin
          col_r <= col_r - col_t'(1);
        end
      end

      if (s1_adv && !cfg_we) begin
        total_r <= total_nxt;
      end

      if (in_acc) begin
        s1_v_r  <= 1'b1;
        fwd_v_r <= s1_adv && (s1_r.col == col_r);
      end else if (s1_adv) begin
        s1_v_r  <= 1'b0;
      end

      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r      <= in_ctl;
      fwd_cnt_r <= count;
    end
    if (s1_adv) begin
      right_r     <= count;
      out_total_r <= new_total;
      out_count_r <= count;
      out_last_r  <= s1_r.last;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.running_total = out_total_r;
  assign out_ch.cell_count    = out_count_r;
  assign out_ch.last_cell     = out_last_r;

endmodule

>>> rtl/core/gpc_checker.sv
`timescale 1ns / 1ps

module gpc_checker import gpc_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input count_t running_total,
  input count_t cell_count,
  input logic   last_cell
);

  logic [1:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign pend_nxt = pend_r + {1'b0, in_acc} - {1'b0, out_acc};

  // Items taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(running_total)
      && $stable(cell_count) && $stable(last_cell))
    else $error("result changed while stalled");

  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (running_total < PRIME_MOD) && (cell_count < PRIME_MOD))
    else $error("result not reduced modulo the prime");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 2'd2)
    else $error("more items in flight than pipeline stages");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result offered with no item in flight");

endmodule

bind grid_path_count_mod gpc_checker u_gpc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .running_total (out_ch.running_total),
  .cell_count    (out_ch.cell_count),
  .last_cell     (out_ch.last_cell)
);

>>> tb/tb_grid_path_count_mod.sv
`timescale 1ns / 1ps

module tb_grid_path_count_mod;
  import gpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    count_t total;
    count_t count;
    logic   last;
  } path_res_t;

  typedef struct {
    logic      pinned;
    path_res_t val;
  } pin_t;

  typedef struct {
    logic      is_cfg;
    cfg_reg_t  reg_sel;
    size_t     value;
    kind_t     kind;
    logic      pinned;
    path_res_t pin_val;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0] cfg_data;

  gpc_in_if  in_ch ();
  gpc_out_if out_ch ();

  grid_path_count_mod dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state, mirroring what the block keeps.
  count_t line_counts [MAX_COLS];
  count_t east_count;
  count_t sum_acc;
  col_t   cur_col;
  row_t   cur_row;
  size_t  rows_cfg;
  size_t  cols_cfg;

  path_res_t expected_q [$];
  pin_t      pin_q [$];
  dir_row_t  dir_tab [$];

  int err_cnt = 0;
  int cycle_cnt = 0;
  int cells_sent = 0;
  int results_seen = 0;
  int grids_done = 0;
  int cfg_writes = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;
  int holds_taken = 0;
  int hold_left = 0;

  // Stimulus-side view of the grid in use.
  bit    grid_complete = 1'b0;
  size_t tb_rows_val = size_t'(1);
  size_t tb_cols_val = size_t'(1);

  function automatic int eff_size(size_t v, int lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic count_t mod_add(count_t a, count_t b);
    logic [CNT_W+1:0] s;
    s = {2'b00, a} + {2'b00, b};
    if (s >= {2'b00, PRIME_MOD}) s = s - {2'b00, PRIME_MOD};
    return s[CNT_W-1:0];
  endfunction

  function automatic void restart_grid_model();
    cur_col = col_t'(eff_size(cols_cfg, MAX_COLS) - 1);
    cur_row = row_t'(eff_size(rows_cfg, MAX_ROWS) - 1);
    east_count = '0;
    sum_acc = '0;
  endfunction

  function automatic void reset_model();
    foreach (line_counts[i]) line_counts[i] = '0;
    rows_cfg = size_t'(1);
    cols_cfg = size_t'(1);
    restart_grid_model();
  endfunction

  function automatic void apply_cfg(cfg_reg_t r, size_t v);
    case (r)
      REG_GRID_ROWS: rows_cfg = v;
      REG_GRID_COLS: cols_cfg = v;
      default: ;
    endcase
    restart_grid_model();
  endfunction

  function automatic path_res_t step_model(kind_t k);
    int ncols;
    int nrows;
    int c;
    int rw;
    count_t below;
    count_t right;
    count_t cnt;
    path_res_t res;
    ncols = eff_size(cols_cfg, MAX_COLS);
    nrows = eff_size(rows_cfg, MAX_ROWS);
    c = int'(cur_col);
    rw = int'(cur_row);
    if (c >= ncols) c = ncols - 1;
    if (rw >= nrows) rw = nrows - 1;
    // A neighbour outside the map contributes nothing.
    below = (rw == nrows - 1) ? '0 : line_counts[c];
    right = (c == ncols - 1) ? '0 : east_count;
    case (k)
      KIND_GOAL:  cnt = count_t'(1);
      KIND_EAST:  cnt = right;
      KIND_SOUTH: cnt = below;
      default:    cnt = mod_add(below, right);
    endcase
    sum_acc = mod_add(sum_acc, cnt);
    line_counts[c] = cnt;
    east_count = cnt;
    res.total = sum_acc;
    res.count = cnt;
    res.last = (rw == 0 && c == 0);
    if (res.last) begin
      restart_grid_model();
    end else if (c == 0) begin
      cur_col = col_t'(ncols - 1);
      cur_row = row_t'(rw - 1);
      east_count = '0;
    end else begin
      cur_col = col_t'(c - 1);
      cur_row = row_t'(rw);
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, count_t got, count_t want);
    if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Prediction on every input transfer, comparison on every result transfer.
  always @(posedge clk) begin : model_blk
    path_res_t r;
    path_res_t e;
    pin_t p;
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_we) apply_cfg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_ch.valid && in_ch.ready) begin
        r = step_model(in_ch.cell_kind);
        p = pin_q.pop_front();
        expected_q.push_back(p.pinned ? p.val : r);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer with no result expected");
        end else begin
          e = expected_q.pop_front();
          check_field("running_total", out_ch.running_total, e.total);
          check_field("cell_count", out_ch.cell_count, e.count);
          check_field("last_cell", count_t'(out_ch.last_cell), count_t'(e.last));
          if (out_ch.last_cell) grids_done++;
        end
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    if (hold_asks != holds_taken) begin
      holds_taken = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results outstanding.",
               expected_q.size());
      $display("** grid_path_count_mod: FAILED **");
      $finish;
    end
  end

  task automatic send_cell(kind_t k, logic pin, path_res_t pin_val);
    pin_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    p.pinned = pin;
    p.val = pin_val;
    pin_q.push_back(p);
    in_ch.valid <= 1'b1;
    in_ch.cell_kind <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cells_sent++;
  endtask

  // Leaves valid low and waits until every expected result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, size_t v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  function automatic dir_row_t cfg_row(cfg_reg_t r, int v);
    dir_row_t d;
    d.is_cfg = 1'b1;
    d.reg_sel = r;
    d.value = size_t'(v);
    d.kind = KIND_EAST;
    d.pinned = 1'b0;
    d.pin_val = '0;
    return d;
  endfunction

  function automatic dir_row_t cell_row(kind_t k, bit pin, int t, int c, bit l);
    dir_row_t d;
    d.is_cfg = 1'b0;
    d.reg_sel = REG_GRID_ROWS;
    d.value = '0;
    d.kind = k;
    d.pinned = pin;
    d.pin_val.total = count_t'(t);
    d.pin_val.count = count_t'(c);
    d.pin_val.last = l;
    return d;
  endfunction

  // Mode 0 is noise, mode 1 a mixed map, mode 2 a dense map that grows large counts.
  function automatic kind_t pick_kind(int mode, bit first);
    int roll;
    roll = $urandom_range(99);
    if (mode == 0) return kind_t'($urandom_range(3));
    if (first) return KIND_GOAL;
    if (mode == 2) return (roll < 3) ? KIND_GOAL : KIND_BOTH;
    if (roll < 6) return KIND_GOAL;
    if (roll < 60) return KIND_BOTH;
    if (roll < 80) return KIND_EAST;
    return KIND_SOUTH;
  endfunction

  task automatic configure_grid(size_t rv, size_t cv);
    wait_drained();
    write_reg(REG_GRID_ROWS, rv);
    write_reg(REG_GRID_COLS, cv);
    tb_rows_val = rv;
    tb_cols_val = cv;
  endtask

  task automatic send_cells(int n, int mode);
    for (int i = 0; i < n; i++) send_cell(pick_kind(mode, i == 0), 1'b0, '0);
  endtask

  task automatic run_random(int n_cells, int s_pct, int r_pct);
    int target;
    int cells;
    int to_send;
    int mode;
    size_t rv;
    size_t cv;
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    target = cells_sent + n_cells;
    while (cells_sent < target) begin
      // A finished grid may be followed by a fresh one of the same size without a write.
      if (!(grid_complete && $urandom_range(3) == 0)) begin
        case ($urandom_range(19))
          0: begin rv = '0; cv = size_t'($urandom_range(1, 12)); end
          1: begin rv = size_t'($urandom_range(1, 8)); cv = '0; end
          2: begin rv = size_t'($urandom_range(4090, 8191)); cv = size_t'($urandom_range(1, 3)); end
          3: begin rv = size_t'($urandom_range(1, 3)); cv = size_t'($urandom_range(4090, 8191)); end
          default: begin
            rv = size_t'($urandom_range(1, 8));
            cv = size_t'($urandom_range(1, 12));
          end
        endcase
        configure_grid(rv, cv);
      end
      cells = eff_size(tb_rows_val, MAX_ROWS) * eff_size(tb_cols_val, MAX_COLS);
      if (cells > 1 && (cells > 200 || $urandom_range(99) < 15)) begin
        to_send = $urandom_range(1, (cells - 1 < 40) ? cells - 1 : 40);
      end else begin
        to_send = cells;
      end
      mode = ($urandom_range(4) == 0) ? 0 : 1;
      send_cells(to_send, mode);
      grid_complete = (to_send == cells);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_GRID_ROWS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cell_kind = KIND_EAST;
    out_ch.ready = 1'b0;

    // After reset the map is one cell, so each item is both first and last.
    dir_tab.push_back(cell_row(KIND_GOAL, 1, 1, 1, 1));
    dir_tab.push_back(cell_row(KIND_EAST, 1, 0, 0, 1));
    dir_tab.push_back(cell_row(KIND_SOUTH, 1, 0, 0, 1));
    dir_tab.push_back(cell_row(KIND_BOTH, 1, 0, 0, 1));
    // Sizes of zero behave as one.
    dir_tab.push_back(cfg_row(REG_GRID_ROWS, 0));
    dir_tab.push_back(cfg_row(REG_GRID_COLS, 0));
    dir_tab.push_back(cell_row(KIND_GOAL, 1, 1, 1, 1));
    // Two rows of three: bottom row walks east, top row reads the line buffer.
    dir_tab.push_back(cfg_row(REG_GRID_ROWS, 2));
    dir_tab.push_back(cfg_row(REG_GRID_COLS, 3));
    dir_tab.push_back(cell_row(KIND_GOAL, 1, 1, 1, 0));
    dir_tab.push_back(cell_row(KIND_EAST, 1, 2, 1, 0));
    dir_tab.push_back(cell_row(KIND_EAST, 1, 3, 1, 0));
    dir_tab.push_back(cell_row(KIND_SOUTH, 1, 4, 1, 0));
    dir_tab.push_back(cell_row(KIND_BOTH, 1, 6, 2, 0));
    dir_tab.push_back(cell_row(KIND_BOTH, 1, 9, 3, 1));
    // The grid starts over after its last cell; neighbours off the map count zero,
    // and a goal in the middle of the map still counts one.
    dir_tab.push_back(cell_row(KIND_EAST, 1, 0, 0, 0));
    dir_tab.push_back(cell_row(KIND_GOAL, 1, 1, 1, 0));
    dir_tab.push_back(cell_row(KIND_SOUTH, 1, 1, 0, 0));
    dir_tab.push_back(cell_row(KIND_GOAL, 1, 2, 1, 0));
    dir_tab.push_back(cell_row(KIND_EAST, 1, 3, 1, 0));
    dir_tab.push_back(cell_row(KIND_SOUTH, 1, 3, 0, 1));
    // Sizes above the limit behave as the limit; a write abandons the grid in progress.
    dir_tab.push_back(cfg_row(REG_GRID_COLS, 8191));
    dir_tab.push_back(cfg_row(REG_GRID_ROWS, 4096));
    dir_tab.push_back(cell_row(KIND_GOAL, 0, 0, 0, 0));
    dir_tab.push_back(cell_row(KIND_BOTH, 0, 0, 0, 0));
    dir_tab.push_back(cell_row(KIND_BOTH, 0, 0, 0, 0));
    dir_tab.push_back(cfg_row(REG_GRID_ROWS, 8191));
    dir_tab.push_back(cfg_row(REG_GRID_COLS, 1));
    dir_tab.push_back(cell_row(KIND_GOAL, 0, 0, 0, 0));
    dir_tab.push_back(cell_row(KIND_SOUTH, 0, 0, 0, 0));
    dir_tab.push_back(cell_row(KIND_BOTH, 0, 0, 0, 0));
    dir_tab.push_back(cell_row(KIND_EAST, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_drained();
        write_reg(dir_tab[i].reg_sel, dir_tab[i].value);
      end else begin
        send_cell(dir_tab[i].kind, dir_tab[i].pinned, dir_tab[i].pin_val);
      end
    end
    grid_complete = 1'b0;

    run_random(170, 0, 0);

    // An 18 x 18 map of mostly two-way cells pushes counts past the prime. The
    // receiver holds off while cells keep coming, then the sender waits for the
    // pipeline to empty before finishing the map.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure_grid(size_t'(18), size_t'(18));
    hold_asks++;
    send_cells(162, 2);
    wait_drained();
    for (int i = 0; i < 162; i++) send_cell(pick_kind(2, 1'b0), 1'b0, '0);
    grid_complete = 1'b1;

    run_random(170, 75, 0);
    run_random(170, 0, 75);
    run_random(170, 25, 25);

    recv_stall_pct = 0;
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d cells and checked %0d results over %0d finished grids.",
             cells_sent, results_seen, grids_done);
    $display("Made %0d register writes; sizes ranged from zero to beyond the limit.",
             cfg_writes);
    if (err_cnt == 0) begin
      $display("** grid_path_count_mod: PASSED **");
    end else begin
      $display("** grid_path_count_mod: FAILED **");
    end
    $finish;
  end

endmodule
